/* src/ldi_pkg.sv */
// Shared types and constants for the disjunctive network inference block.
// No dependencies; imported by ldnn_disjunction_inference.
package ldi_pkg;

    // Default sizes of the stores and of the sigmoid table.
    localparam int MAX_FEATURES_DEF        = 64;
    localparam int MAX_DISCRIMINANTS_DEF   = 64;
    localparam int SIGMOID_TABLE_DEPTH_DEF = 1024;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_NUM_FEATURES = 2'd0;
    localparam logic [1:0] CFG_NUM_GROUPS   = 2'd1;
    localparam logic [1:0] CFG_PER_GROUP    = 2'd2;

    // Kinds of input word carried in tuser.
    localparam logic REQ_WEIGHT  = 1'b0;
    localparam logic REQ_FEATURE = 1'b1;

    // Q0.16 one, rounding offset and the Q4.12 one used against the bias.
    localparam logic [15:0]        Q_ONE        = 16'hFFFF;
    localparam logic [31:0]        Q_ROUND      = 32'd32767;
    localparam logic signed [15:0] BIAS_FEATURE = 16'sd4096;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GRP,
        S_MAC,
        S_DRAIN,
        S_SIGIDX,
        S_ROM,
        S_GMUL1,
        S_GMUL2,
        S_OMUL1,
        S_OMUL2,
        S_DONE
    } t_state;

endpackage

/* src/ldnn_disjunction_inference.sv */
// Top level of the disjunctive network inference block: weight and feature stores,
// shared multiply-accumulate, sigmoid ROM and Q0.16 product unit. Depends on ldi_pkg.
//
// Weight words (tuser = 0) are written into the weight memory; feature words
// (tuser = 1) are buffered in the feature store. The feature word marked tlast
// starts evaluation, during which no input word is taken. Each used discriminant
// reads its weights and then its bias over the single read port of the weight
// memory, followed by pipeline drain, sigmoid lookup and group multiply; each
// group adds a set-up step and the outer product. A sample whose length is wrong
// skips evaluation and gives an error result. The result waits in an output
// register, so the next words are taken while it is pending. There is no
// clearing pass after reset.
module ldnn_disjunction_inference
    import ldi_pkg::*;
#(
    parameter int MAX_FEATURES        = MAX_FEATURES_DEF,
    parameter int MAX_DISCRIMINANTS   = MAX_DISCRIMINANTS_DEF,
    parameter int SIGMOID_TABLE_DEPTH = SIGMOID_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] disc_index, [12:6] weight_slot, [28:13] value, [31:29] zero
    input  logic [31:0] i_s_tdata,
    // [0] req_type
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] probability
    output logic [15:0] o_m_tdata,
    // [0] length_error
    output logic        o_m_tuser
);

    localparam int ROW   = MAX_FEATURES + 1;
    localparam int WDEP  = MAX_DISCRIMINANTS * ROW;
    localparam int AW    = $clog2(WDEP);
    localparam int FIW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int KW    = $clog2(MAX_FEATURES + 1);
    localparam int CW    = $clog2(MAX_FEATURES + 2);
    localparam int BW    = $clog2(MAX_DISCRIMINANTS + 65);
    localparam int IW    = $clog2(SIGMOID_TABLE_DEPTH);

    typedef logic [15:0] t_sig_tbl [SIGMOID_TABLE_DEPTH];

    // Long division of non-negative operands, used only while building the table.
    function automatic longint cdiv(input longint a, input longint b);
        longint q, r;
        q = 0;
        r = 0;
        for (int n = 62; n >= 0; n--) begin
            r = (r <<< 1) | ((a >>> n) & 64'sd1);
            q = q <<< 1;
            if (r >= b) begin
                r = r - b;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Sigmoid at the centre of bin i, from a Taylor series of exp(-x/16)
    // raised to the sixteenth power by four squarings.
    function automatic logic [15:0] sig_entry(input int i);
        longint c, m, u, w, term, sum, e, num, den;
        c = longint'(2 * i + 1) - longint'(SIGMOID_TABLE_DEPTH);
        m = (c < 0) ? -c : c;
        u = (m <<< 33) / SIGMOID_TABLE_DEPTH;
        w = u >>> 4;
        term = 64'sd1 <<< 30;
        sum  = term;
        for (int k = 1; k <= 12; k++) begin
            term = cdiv((term * w) >>> 30, longint'(k));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        e = sum;
        for (int k = 0; k < 4; k++) begin
            e = (e * e) >>> 30;
        end
        den = (64'sd1 <<< 30) + e;
        num = (c > 0) ? (64'sd1 <<< 30) : e;
        return 16'(cdiv(65535 * num + den / 2, den));
    endfunction

    function automatic t_sig_tbl build_tbl();
        t_sig_tbl t;
        for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
            t[i] = sig_entry(i);
        end
        return t;
    endfunction

    localparam t_sig_tbl SIG_TBL = build_tbl();

    // Exact floor(x / 65535) for x below 65535 * 65535 + 32768.
    function automatic logic [15:0] qfix(input logic [31:0] x);
        logic [16:0] rem;
        rem = 17'(x[15:0]) + 17'(x[31:16]);
        return (rem >= 17'd65535) ? x[31:16] + 16'd1 : x[31:16];
    endfunction

    // Memories.
    logic [15:0] r_wmem [WDEP];
    logic [15:0] r_fmem [MAX_FEATURES];

    // Control state.
    t_state      r_state, n_state;
    logic [6:0]  r_nf, r_ng, r_pg;
    logic [CW-1:0] r_fcnt;
    logic        r_v1, r_v2, r_b1;
    logic        r_ovalid;

    // Payload.
    logic [15:0]        r_wrd, r_frd;
    logic signed [31:0] r_prod;
    logic signed [31:0] r_acc;
    logic [KW-1:0]      r_k;
    logic [BW-1:0]      r_disc, r_base;
    logic [6:0]         r_dcnt, r_g;
    logic [IW-1:0]      r_idx;
    logic [15:0]        r_sig, r_gprod, r_outer;
    logic [31:0]        r_qp;
    logic [15:0]        r_res_prob;
    logic               r_res_err;
    logic [15:0]        r_prob;
    logic               r_err;

    // Input fields.
    logic [5:0]  in_disc;
    logic [6:0]  in_slot;
    logic [15:0] in_value;
    assign in_disc  = i_s_tdata[5:0];
    assign in_slot  = i_s_tdata[12:6];
    assign in_value = i_s_tdata[28:13];

    logic          s_acc, feat_acc, wt_acc, len_ok, grp_ok, out_free, bias_issue;
    logic [CW-1:0] fcnt_next;
    logic [AW-1:0] rd_addr, wr_addr;
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_clamp;
    logic [27:0]   sig_off;
    logic [63:0]   sig_scaled;
    logic [15:0]   qa, qb;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign feat_acc = s_acc && (i_s_tuser == REQ_FEATURE);
    assign wt_acc   = s_acc && (i_s_tuser == REQ_WEIGHT) &&
                      (int'(in_disc) < MAX_DISCRIMINANTS) && (int'(in_slot) <= MAX_FEATURES);
    assign fcnt_next = (int'(r_fcnt) <= MAX_FEATURES) ? r_fcnt + CW'(1) : r_fcnt;
    assign len_ok   = (r_nf != 7'd0) && (int'(r_nf) <= MAX_FEATURES) &&
                      (int'(fcnt_next) == int'(r_nf));
    assign grp_ok   = (r_g < r_ng) && (int'(r_base) + int'(r_pg) <= MAX_DISCRIMINANTS);
    assign out_free = !r_ovalid || i_m_tready;
    assign bias_issue = (int'(r_k) == int'(r_nf));

    assign wr_addr = AW'(int'(in_disc) * ROW + int'(in_slot));
    assign rd_addr = AW'(int'(r_disc) * ROW + (bias_issue ? MAX_FEATURES : int'(r_k)));

    assign acc_sum = 33'(r_acc) + 33'(r_prod);

    always_comb begin
        if (r_acc < -(32'sd1 <<< 27)) begin
            acc_clamp = -(32'sd1 <<< 27);
        end else if (r_acc > (32'sd1 <<< 27) - 32'sd1) begin
            acc_clamp = (32'sd1 <<< 27) - 32'sd1;
        end else begin
            acc_clamp = r_acc;
        end
        sig_off    = 28'(acc_clamp + (32'sd1 <<< 27));
        sig_scaled = 64'(sig_off) * 64'(SIGMOID_TABLE_DEPTH);
    end

    // Operands of the shared Q0.16 multiplier.
    always_comb begin
        if (r_state == S_OMUL1) begin
            qa = r_outer;
            qb = ~r_gprod;
        end else begin
            qa = r_gprod;
            qb = r_sig;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (feat_acc && i_s_tlast) begin
                    n_state = len_ok ? S_GRP : S_DONE;
                end
            end
            S_GRP: begin
                if (!grp_ok) begin
                    n_state = S_DONE;
                end else if (r_pg == 7'd0) begin
                    n_state = S_OMUL1;
                end else begin
                    n_state = S_MAC;
                end
            end
            S_MAC:    if (bias_issue) n_state = S_DRAIN;
            S_DRAIN:  if (!r_v1 && !r_v2) n_state = S_SIGIDX;
            S_SIGIDX: n_state = S_ROM;
            S_ROM:    n_state = S_GMUL1;
            S_GMUL1:  n_state = S_GMUL2;
            S_GMUL2:  n_state = (r_dcnt + 7'd1 == r_pg) ? S_OMUL1 : S_MAC;
            S_OMUL1:  n_state = S_OMUL2;
            S_OMUL2:  n_state = S_GRP;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the controller.
    always_comb begin
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE:  o_s_tready = 1'b1;
            default: o_s_tready = 1'b0;
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_prob;
    assign o_m_tuser  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nf     <= 7'd1;
            r_ng     <= 7'd1;
            r_pg     <= 7'd1;
            r_fcnt   <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NUM_FEATURES: r_nf <= i_cfg_data;
                    CFG_NUM_GROUPS:   r_ng <= i_cfg_data;
                    CFG_PER_GROUP:    r_pg <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (feat_acc) begin
                r_fcnt <= i_s_tlast ? '0 : fcnt_next;
            end
            r_v1 <= (r_state == S_MAC);
            r_v2 <= r_v1;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Memories: writes only while idle; the read registers load on every cycle.
    always_ff @(posedge i_clk) begin
        if (wt_acc) begin
            r_wmem[wr_addr] <= in_value;
        end
        if (feat_acc && (int'(r_fcnt) < MAX_FEATURES)) begin
            r_fmem[r_fcnt[FIW-1:0]] <= in_value;
        end
        r_wrd <= r_wmem[rd_addr];
        r_frd <= r_fmem[r_k[FIW-1:0]];
        r_b1  <= bias_issue;
        r_sig <= SIG_TBL[r_idx];
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= $signed(r_wrd) * (r_b1 ? BIAS_FEATURE : $signed(r_frd));
        r_qp   <= 32'(qa) * 32'(qb) + Q_ROUND;
        if (r_v2) begin
            if (acc_sum[32] != acc_sum[31]) begin
                r_acc <= acc_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
            end else begin
                r_acc <= acc_sum[31:0];
            end
        end
        // The output word only changes when the previous one has gone.
        if (r_state == S_DONE && out_free) begin
            r_prob <= r_res_prob;
            r_err  <= r_res_err;
        end
        case (r_state)
            S_IDLE: begin
                r_outer <= Q_ONE;
                r_g     <= '0;
                r_base  <= '0;
                if (feat_acc && i_s_tlast && !len_ok) begin
                    r_res_prob <= '0;
                    r_res_err  <= 1'b1;
                end
            end
            S_GRP: begin
                r_gprod <= Q_ONE;
                r_dcnt  <= '0;
                r_disc  <= r_base;
                r_k     <= '0;
                r_acc   <= '0;
                if (!grp_ok) begin
                    r_res_prob <= ~r_outer;
                    r_res_err  <= 1'b0;
                end
            end
            S_MAC:    r_k <= r_k + KW'(1);
            S_SIGIDX: r_idx <= sig_scaled[28 +: IW];
            S_GMUL2: begin
                r_gprod <= qfix(r_qp);
                r_disc  <= r_disc + BW'(1);
                r_dcnt  <= r_dcnt + 7'd1;
                r_k     <= '0;
                r_acc   <= '0;
            end
            S_OMUL2: begin
                r_outer <= qfix(r_qp);
                r_g     <= r_g + 7'd1;
                r_base  <= r_base + BW'(r_pg);
            end
            default: ;
        endcase
    end

    // The multiply-accumulate pipeline runs only while weights are issued or drained.
    a_pipe_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_MAC || r_state == S_DRAIN))
        else $error("accumulator pipeline active outside evaluation");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SIGIDX) |-> (!r_v1 && !r_v2))
        else $error("sigmoid index taken before accumulator settled");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("finished result not presented");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fcnt) <= MAX_FEATURES + 1)
        else $error("feature count beyond saturation");

    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("input word taken during evaluation");

endmodule

/* tb/ldnn_disjunction_inference_tb.sv */
// Self-checking testbench for ldnn_disjunction_inference: weight loading, feature
// samples and length errors, checked against a predictor. Depends on ldi_pkg and the RTL.
`timescale 1ns / 100ps

module ldnn_disjunction_inference_tb;
    import ldi_pkg::*;

    localparam int NF = 64;
    localparam int ND = 64;
    localparam int SDEPTH = 1024;
    localparam int LIMIT = 3000000;
    localparam int QUIET_CYCLES = 40;
    localparam int LOAD_D = 16;
    localparam int LOAD_F = 16;

    typedef struct {
        logic        kind;
        logic [5:0]  disc;
        logic [6:0]  slot;
        logic [15:0] value;
        logic        last;
        bit          typed;
        logic [15:0] prob;
        logic        err;
    } t_word;

    typedef struct {
        logic [15:0] prob;
        logic        err;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;

    ldnn_disjunction_inference dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state.
    logic [15:0] wmem [ND][NF+1];
    logic [15:0] fmem [NF];
    logic [15:0] dprob [ND];
    int unsigned fcount;
    int unsigned cfg_nf = 1, cfg_ng = 1, cfg_pg = 1;
    logic [15:0] sig_rom [SDEPTH];

    t_verdict pending [$];
    bit  idling = 1'b1;
    int  mismatches = 0;
    int  results_seen = 0;
    int  words_sent = 0;
    int  cycles = 0;

    function automatic logic [15:0] sig_bin(int i);
        longint c, m, u, w, term, sum, e, num, den;
        c = 2 * i + 1 - SDEPTH;
        m = (c < 0) ? -c : c;
        u = (m << 33) / SDEPTH;
        w = u >>> 4;
        term = longint'(1) << 30;
        sum = term;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * w) >>> 30) / k;
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        e = sum;
        for (int k = 0; k < 4; k++) e = (e * e) >>> 30;
        den = (longint'(1) << 30) + e;
        num = (c > 0) ? (longint'(1) << 30) : e;
        return 16'((65535 * num + den / 2) / den);
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul16(longint a, longint b);
        return (a * b + 32767) / 65535;
    endfunction

    function automatic logic [15:0] network_prob();
        int unsigned groups;
        longint acc, off, idx, prod, outer;
        groups = cfg_ng;
        if (cfg_pg > 0 && groups > ND / cfg_pg) groups = ND / cfg_pg;
        outer = 65535;
        for (int d = 0; d < groups * cfg_pg && d < ND; d++) begin
            acc = 0;
            for (int k = 0; k < cfg_nf && k < NF; k++)
                acc = clip32(acc + longint'($signed(wmem[d][k])) *
                                   longint'($signed(fmem[k])));
            acc = clip32(acc + longint'($signed(wmem[d][NF])) * 4096);
            if (acc < -(longint'(8) << 24)) acc = -(longint'(8) << 24);
            if (acc > (longint'(8) << 24) - 1) acc = (longint'(8) << 24) - 1;
            off = acc + (longint'(8) << 24);
            idx = (off * SDEPTH) >>> 28;
            if (idx >= SDEPTH) idx = SDEPTH - 1;
            dprob[d] = sig_rom[idx];
        end
        for (int g = 0; g < groups; g++) begin
            prod = 65535;
            for (int k = 0; k < cfg_pg; k++)
                if (g * cfg_pg + k < ND) prod = qmul16(prod, dprob[g * cfg_pg + k]);
            outer = qmul16(outer, 65535 - prod);
        end
        return 16'(65535 - outer);
    endfunction

    // Updates the predictor with one accepted word and queues any result it causes.
    task automatic absorb_word(t_word wd);
        t_verdict v;
        bit ok;
        if (wd.kind == REQ_WEIGHT) begin
            if (wd.slot <= NF) wmem[wd.disc][wd.slot] = wd.value;
            return;
        end
        if (fcount < NF) fmem[fcount] = wd.value;
        if (fcount <= NF) fcount++;
        if (!wd.last) return;
        ok = cfg_nf >= 1 && cfg_nf <= NF && fcount == cfg_nf;
        fcount = 0;
        if (ok) begin
            v.prob = network_prob();
            v.err = 1'b0;
        end else begin
            v.prob = '0;
            v.err = 1'b1;
        end
        if (wd.typed) begin
            v.prob = wd.prob;
            v.err = wd.err;
        end
        pending.push_back(v);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_word wd);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= wd.kind;
        i_s_tlast  <= wd.last;
        i_s_tdata  <= {3'b000, wd.value, wd.slot, wd.disc};
        do @(posedge i_clk); while (!o_s_tready);
        absorb_word(wd);
        words_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_word mk(logic kind, int disc, int slot, logic [15:0] value,
                                 logic last, bit typed = 0, logic [15:0] prob = 0,
                                 logic err = 0);
        t_word wd;
        wd.kind = kind;
        wd.disc = 6'(disc);
        wd.slot = 7'(slot);
        wd.value = value;
        wd.last = last;
        wd.typed = typed;
        wd.prob = prob;
        wd.err = err;
        return wd;
    endfunction

    function automatic logic [15:0] rand_value();
        if ($urandom_range(0, 1) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 2047) - 1024);
    endfunction

    task automatic write_regs(int nf, int ng, int pg);
        int vals [3];
        vals = '{nf, ng, pg};
        for (int r = 0; r < 3; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= 2'(r);
            i_cfg_data <= 7'(vals[r]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_nf = nf;
        cfg_ng = ng;
        cfg_pg = pg;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_sample(int len);
        for (int k = 0; k < len; k++)
            send_word(mk(REQ_FEATURE, $urandom_range(0, 63), $urandom_range(0, 127),
                         rand_value(), k == len - 1));
    endtask

    // Receiver back-pressure.
    initial begin
        forever begin
            @(negedge i_clk);
            if (idling && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict v;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("ldnn_disjunction_inference_tb failed");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result prob=%0d err=%0b", o_m_tdata, o_m_tuser);
            end else begin
                v = pending.pop_front();
                if (o_m_tdata !== v.prob || o_m_tuser !== v.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected prob=%0d err=%0b, got prob=%0d err=%0b",
                                 v.prob, v.err, o_m_tdata, o_m_tuser);
                end
            end
        end
    end

    initial begin
        t_word table_rows [$];
        int phase_cfg [10][3];
        int budget, start, nf, r;
        for (int i = 0; i < SDEPTH; i++) sig_rom[i] = sig_bin(i);
        fcount = 0;
        phase_cfg = '{'{4, 2, 3}, '{16, 2, 8}, '{0, 1, 1}, '{3, 127, 127}, '{5, 0, 2},
                      '{3, 4, 0}, '{8, 16, 1}, '{2, 1, 16}, '{127, 3, 3}, '{6, 3, 2}};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Load the weights and biases of the first discriminants; no setting below
        // evaluates a discriminant or a feature position beyond them.
        for (int d = 0; d < LOAD_D; d++)
            for (int s = 0; s <= LOAD_F; s++)
                send_word(mk(REQ_WEIGHT, d, (s == LOAD_F) ? NF : s, rand_value(),
                             $urandom_range(0, 1)));

        // Directed words at the reset setting: one feature, one discriminant.
        table_rows.push_back(mk(REQ_WEIGHT, 0, 0, 16'h7FFF, 0));
        table_rows.push_back(mk(REQ_WEIGHT, 0, NF, 16'h7FFF, 0));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h7FFF, 1));
        table_rows.push_back(mk(REQ_WEIGHT, 0, 0, 16'h8000, 0));
        table_rows.push_back(mk(REQ_FEATURE, 63, 127, 16'h7FFF, 1));
        table_rows.push_back(mk(REQ_WEIGHT, 0, NF, 16'h8000, 1));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h8000, 1));
        table_rows.push_back(mk(REQ_WEIGHT, 0, 0, 16'h0000, 0));
        table_rows.push_back(mk(REQ_WEIGHT, 0, NF, 16'h0000, 0));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h1234, 1));
        // Out-of-range slots are dropped, and tlast on a weight word means nothing.
        table_rows.push_back(mk(REQ_WEIGHT, 63, 127, 16'hFFFF, 1));
        table_rows.push_back(mk(REQ_WEIGHT, 63, 65, 16'h5555, 1));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h0000, 0));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h0000, 1, 1, 16'd0, 1'b1));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'hFFFF, 1));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h0001, 0));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h0002, 0));
        table_rows.push_back(mk(REQ_FEATURE, 0, 0, 16'h0003, 1, 1, 16'd0, 1'b1));
        foreach (table_rows[i]) send_word(table_rows[i]);

        // Random phases, one register setting each; the last runs without idling.
        for (int p = 0; p < 10; p++) begin
            wait_idle();
            write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            idling = (p != 9);
            nf = phase_cfg[p][0];
            start = words_sent;
            budget = 50;
            while (words_sent - start < budget) begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    send_word(mk(REQ_WEIGHT, $urandom_range(0, 63),
                                 ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127)
                                                             : $urandom_range(0, NF),
                                 rand_value(), $urandom_range(0, 1)));
                end else if (r < 9) begin
                    send_sample((nf >= 1 && nf <= NF) ? nf : $urandom_range(1, 8));
                end else begin
                    // Random length, often broken, sometimes past the feature store.
                    send_sample(($urandom_range(0, 3) == 0) ? $urandom_range(60, 70)
                                                            : $urandom_range(1, 8));
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
        if (pending.size() != 0) mismatches++;
        $display("Sent %0d words over 11 register settings, checked %0d probabilities.",
                 words_sent, results_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("ldnn_disjunction_inference_tb passed");
        end else begin
            $display("ldnn_disjunction_inference_tb failed");
        end
        $finish;
    end

endmodule
